@@ rtl/hes_pkg.sv @@
// Shared types, op codes and sizing constants for the harmonic edge spring block.
`default_nettype none
package hes_pkg;

   localparam int VERTEX_INDEX_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF         = 16;

   localparam int IDX_W   = 16;
   localparam int WORD_W  = 32;
   localparam int EN_W    = 64;
   localparam int CSR_IDX_W = 8;

   localparam int DIFF_W  = 33;   // magnitude of a coordinate difference
   localparam int SUM_W   = 68;   // sum of three squares, padded to an even width
   localparam int LEN_W   = 34;   // floor square root of SUM_W bits
   localparam int REM_W   = 35;   // square root partial remainder
   localparam int DEV_W   = 35;   // signed len - e0
   localparam int MPL_W   = 34;   // shift-add multiplier operand
   localparam int WORK_W  = 128;  // multiply and divide datapath

   localparam int MUL_STEPS  = MPL_W;
   localparam int SQRT_STEPS = LEN_W;
   localparam int DIV_STEPS  = WORK_W;
   localparam int CNT_W      = 7;

   localparam logic [CSR_IDX_W-1:0] REG_REST_LENGTH = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STIFFNESS   = 8'd1;

   localparam logic [WORD_W-1:0] REST_LENGTH_RST = 32'h0001_0000;
   localparam logic [WORD_W-1:0] STIFFNESS_RST   = 32'h0001_0000;

   localparam logic [4:0] OP_NOP       = 5'd0;
   localparam logic [4:0] OP_LOAD      = 5'd1;
   localparam logic [4:0] OP_SQ_INIT   = 5'd2;
   localparam logic [4:0] OP_MUL_STEP  = 5'd3;
   localparam logic [4:0] OP_SQ_ACC    = 5'd4;
   localparam logic [4:0] OP_SQRT_INIT = 5'd5;
   localparam logic [4:0] OP_SQRT_STEP = 5'd6;
   localparam logic [4:0] OP_DEV       = 5'd7;
   localparam logic [4:0] OP_E1_INIT   = 5'd8;
   localparam logic [4:0] OP_E2_INIT   = 5'd9;
   localparam logic [4:0] OP_EDIV_INIT = 5'd10;
   localparam logic [4:0] OP_DIV_STEP  = 5'd11;
   localparam logic [4:0] OP_ENERGY    = 5'd12;
   localparam logic [4:0] OP_DEN_INIT  = 5'd13;
   localparam logic [4:0] OP_DEN_SAVE  = 5'd14;
   localparam logic [4:0] OP_G1_INIT   = 5'd15;
   localparam logic [4:0] OP_G2_INIT   = 5'd16;
   localparam logic [4:0] OP_GDIV_INIT = 5'd17;
   localparam logic [4:0] OP_GRAD      = 5'd18;
   localparam logic [4:0] OP_FINISH    = 5'd19;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] sel;   // axis for per-component ops
   } cmd_type;

   typedef struct packed {
      logic out_stall;   // result register full and not being taken
   } sts_type;

endpackage
`default_nettype wire

@@ rtl/hes_if.sv @@
// Handshake channel interfaces: edge requests, results and register writes.
`default_nettype none
interface hes_req_if import hes_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         index_a;
   logic [IDX_W-1:0]         index_b;
   logic signed [WORD_W-1:0] pos_ax;
   logic signed [WORD_W-1:0] pos_ay;
   logic signed [WORD_W-1:0] pos_az;
   logic signed [WORD_W-1:0] pos_bx;
   logic signed [WORD_W-1:0] pos_by;
   logic signed [WORD_W-1:0] pos_bz;
   logic                     last_edge;
   modport source (output valid, index_a, index_b, pos_ax, pos_ay, pos_az,
                   pos_bx, pos_by, pos_bz, last_edge, input ready);
   modport sink   (input valid, index_a, index_b, pos_ax, pos_ay, pos_az,
                   pos_bx, pos_by, pos_bz, last_edge, output ready);
endinterface

interface hes_rsp_if import hes_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         out_index_a;
   logic [IDX_W-1:0]         out_index_b;
   logic signed [WORD_W-1:0] grad_x;
   logic signed [WORD_W-1:0] grad_y;
   logic signed [WORD_W-1:0] grad_z;
   logic [WORD_W-1:0]        edge_length;
   logic signed [EN_W-1:0]   energy;
   logic                     last;
   logic                     degenerate;
   modport source (output valid, out_index_a, out_index_b, grad_x, grad_y, grad_z,
                   edge_length, energy, last, degenerate, input ready);
   modport sink   (input valid, out_index_a, out_index_b, grad_x, grad_y, grad_z,
                   edge_length, energy, last, degenerate, output ready);
endinterface

interface hes_csr_if import hes_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [WORD_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/hes_datapath.sv @@
// Datapath: config registers, shift-add multiplier, square root, divider, result register.
`default_nettype none
module hes_datapath import hes_pkg::*; #(
   parameter int VERTEX_INDEX_BITS = VERTEX_INDEX_BITS_DEF,
   parameter int FRAC_BITS         = FRAC_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output      sts_type                  sts,
   input  wire logic                     csr_valid,
   input  wire logic [CSR_IDX_W-1:0]     csr_index,
   input  wire logic [WORD_W-1:0]        csr_data,
   input  wire logic [IDX_W-1:0]         index_a,
   input  wire logic [IDX_W-1:0]         index_b,
   input  wire logic signed [WORD_W-1:0] pos_ax,
   input  wire logic signed [WORD_W-1:0] pos_ay,
   input  wire logic signed [WORD_W-1:0] pos_az,
   input  wire logic signed [WORD_W-1:0] pos_bx,
   input  wire logic signed [WORD_W-1:0] pos_by,
   input  wire logic signed [WORD_W-1:0] pos_bz,
   input  wire logic                     last_edge,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic [IDX_W-1:0]         out_index_a,
   output      logic [IDX_W-1:0]         out_index_b,
   output      logic signed [WORD_W-1:0] grad_x,
   output      logic signed [WORD_W-1:0] grad_y,
   output      logic signed [WORD_W-1:0] grad_z,
   output      logic [WORD_W-1:0]        edge_length,
   output      logic signed [EN_W-1:0]   energy,
   output      logic                     last,
   output      logic                     degenerate
);

   localparam logic [IDX_W-1:0] IDX_MASK = (VERTEX_INDEX_BITS >= IDX_W) ? {IDX_W{1'b1}} :
      IDX_W'((33'd1 << VERTEX_INDEX_BITS) - 33'd1);
   localparam int ESH_L = (2 * FRAC_BITS <= 32) ? 32 - 2 * FRAC_BITS : 0;
   localparam int ESH_R = (2 * FRAC_BITS > 32) ? 2 * FRAC_BITS - 32 : 0;
   localparam logic [MPL_W-1:0] ONE_FRAC = MPL_W'(1) << FRAC_BITS;
   localparam logic [EN_W-1:0]  EN_MAX   = {1'b0, {(EN_W-1){1'b1}}};

   logic [WORD_W-1:0] rest_length_ff, stiffness_ff;
   logic [IDX_W-1:0]  idx_a_ff, idx_b_ff;
   logic              last_ff;
   logic [DIFF_W-1:0] diff_mag_ff [3];
   logic [2:0]        diff_neg_ff;
   logic [SUM_W-1:0]  sum_ff, rad_ff;
   logic [REM_W-1:0]  srem_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [MPL_W-1:0]  dmag_ff;
   logic              dneg_ff;
   logic [WORK_W-1:0] acc_ff, mcand_ff, num_ff, rem_ff, div_den_ff, len_den_ff;
   logic [MPL_W-1:0]  mplier_ff;
   logic [WORD_W-1:0] grad_ff [3];
   logic signed [EN_W-1:0] energy_sum_ff;
   logic              rsp_valid_ff;
   logic [IDX_W-1:0]  o_idx_a_ff, o_idx_b_ff;
   logic [WORD_W-1:0] o_gx_ff, o_gy_ff, o_gz_ff, o_len_ff;
   logic [EN_W-1:0]   o_en_ff;
   logic              o_last_ff, o_degen_ff;

   // stiffness sign and magnitude
   logic              kneg;
   logic [WORD_W-1:0] kmag;
   logic [MPL_W-1:0]  e0_eff;
   assign kneg   = stiffness_ff[WORD_W-1];
   assign kmag   = kneg ? (~stiffness_ff + 32'd1) : stiffness_ff;
   assign e0_eff = (rest_length_ff != '0) ? MPL_W'(rest_length_ff) : ONE_FRAC;

   // coordinate differences
   logic signed [DIFF_W-1:0] dlt [3];
   always_comb begin
      dlt[0] = DIFF_W'(pos_ax) - DIFF_W'(pos_bx);
      dlt[1] = DIFF_W'(pos_ay) - DIFF_W'(pos_by);
      dlt[2] = DIFF_W'(pos_az) - DIFF_W'(pos_bz);
   end

   // square root step
   logic [REM_W+1:0] sq_r2, sq_trial;
   logic             sq_ge;
   assign sq_r2    = {srem_ff, rad_ff[SUM_W-1 -: 2]};
   assign sq_trial = {1'b0, len_ff, 2'b01};
   assign sq_ge    = (sq_r2 >= sq_trial);

   // divide step
   logic [WORK_W-1:0] dv_sh;
   logic              dv_ge;
   assign dv_sh = {rem_ff[WORK_W-2:0], num_ff[WORK_W-1]};
   assign dv_ge = (dv_sh >= div_den_ff);

   // deviation
   logic [DEV_W-1:0] dev;
   assign dev = DEV_W'(len_ff) - DEV_W'(rest_length_ff);

   // energy term and saturating accumulate
   logic [WORK_W-1:0] term_s;
   logic [EN_W-1:0]   term_m, term_t;
   logic [EN_W:0]     en_sum;
   logic [EN_W-1:0]   en_next;
   always_comb begin
      term_s = (num_ff << ESH_L) >> ESH_R;
      term_m = (|term_s[WORK_W-1:EN_W-1]) ? EN_MAX : term_s[EN_W-1:0];
      term_t = kneg ? (~term_m + 64'd1) : term_m;
      en_sum = {energy_sum_ff[EN_W-1], energy_sum_ff} + {term_t[EN_W-1], term_t};
      if (en_sum[EN_W] != en_sum[EN_W-1]) begin
         en_next = en_sum[EN_W] ? {1'b1, {(EN_W-1){1'b0}}} : EN_MAX;
      end else begin
         en_next = en_sum[EN_W-1:0];
      end
   end

   // gradient component saturation
   logic              g_neg;
   logic [WORK_W-1:0] g_lim, g_m;
   logic [WORD_W-1:0] g_val;
   always_comb begin
      g_neg = kneg ^ dneg_ff ^ diff_neg_ff[cmd.sel];
      g_lim = g_neg ? WORK_W'(33'h0_8000_0000) : WORK_W'(33'h0_7FFF_FFFF);
      g_m   = (num_ff > g_lim) ? g_lim : num_ff;
      g_val = g_neg ? (~g_m[WORD_W-1:0] + 32'd1) : g_m[WORD_W-1:0];
      if (len_ff == '0) begin
         g_val = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rest_length_ff <= REST_LENGTH_RST;
         stiffness_ff   <= STIFFNESS_RST;
      end else if (csr_valid) begin
         if (csr_index == REG_REST_LENGTH) begin
            rest_length_ff <= csr_data;
         end else if (csr_index == REG_STIFFNESS) begin
            stiffness_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         energy_sum_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.op == OP_ENERGY) begin
            energy_sum_ff <= en_next;
         end
         if (cmd.op == OP_FINISH) begin
            rsp_valid_ff <= 1'b1;
            if (last_ff) begin
               energy_sum_ff <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         OP_LOAD: begin
            idx_a_ff <= index_a & IDX_MASK;
            idx_b_ff <= index_b & IDX_MASK;
            last_ff  <= last_edge;
            for (int i = 0; i < 3; i++) begin
               diff_neg_ff[i] <= dlt[i][DIFF_W-1];
               diff_mag_ff[i] <= dlt[i][DIFF_W-1] ? (~dlt[i] + 33'd1) : dlt[i];
            end
            sum_ff <= '0;
         end
         OP_SQ_INIT: begin
            mcand_ff  <= WORK_W'(diff_mag_ff[cmd.sel]);
            mplier_ff <= MPL_W'(diff_mag_ff[cmd.sel]);
            acc_ff    <= '0;
         end
         OP_MUL_STEP: begin
            if (mplier_ff[0]) begin
               acc_ff <= acc_ff + mcand_ff;
            end
            mcand_ff  <= mcand_ff << 1;
            mplier_ff <= mplier_ff >> 1;
         end
         OP_SQ_ACC: sum_ff <= sum_ff + acc_ff[SUM_W-1:0];
         OP_SQRT_INIT: begin
            rad_ff  <= sum_ff;
            srem_ff <= '0;
            len_ff  <= '0;
         end
         OP_SQRT_STEP: begin
            srem_ff <= sq_ge ? REM_W'(sq_r2 - sq_trial) : REM_W'(sq_r2);
            len_ff  <= {len_ff[LEN_W-2:0], sq_ge};
            rad_ff  <= rad_ff << 2;
         end
         OP_DEV: begin
            dneg_ff <= dev[DEV_W-1];
            dmag_ff <= dev[DEV_W-1] ? MPL_W'(~dev + 35'd1) : MPL_W'(dev);
         end
         OP_E1_INIT: begin
            mcand_ff  <= WORK_W'(dmag_ff);
            mplier_ff <= dmag_ff;
            acc_ff    <= '0;
         end
         OP_E2_INIT: begin
            mcand_ff  <= acc_ff;
            mplier_ff <= MPL_W'(kmag);
            acc_ff    <= '0;
         end
         OP_EDIV_INIT: begin
            num_ff     <= acc_ff;
            rem_ff     <= '0;
            div_den_ff <= WORK_W'(e0_eff);
         end
         OP_DIV_STEP: begin
            rem_ff <= dv_ge ? (dv_sh - div_den_ff) : dv_sh;
            num_ff <= {num_ff[WORK_W-2:0], dv_ge};
         end
         OP_DEN_INIT: begin
            mcand_ff  <= WORK_W'(len_ff);
            mplier_ff <= e0_eff;
            acc_ff    <= '0;
         end
         OP_DEN_SAVE: len_den_ff <= acc_ff;
         OP_G1_INIT: begin
            mcand_ff  <= WORK_W'(diff_mag_ff[cmd.sel]);
            mplier_ff <= dmag_ff;
            acc_ff    <= '0;
         end
         OP_G2_INIT: begin
            mcand_ff  <= acc_ff;
            mplier_ff <= MPL_W'({kmag, 1'b0});
            acc_ff    <= '0;
         end
         OP_GDIV_INIT: begin
            num_ff     <= acc_ff;
            rem_ff     <= '0;
            div_den_ff <= len_den_ff;
         end
         OP_GRAD: grad_ff[cmd.sel] <= g_val;
         OP_FINISH: begin
            o_idx_a_ff <= idx_a_ff;
            o_idx_b_ff <= idx_b_ff;
            o_gx_ff    <= grad_ff[0];
            o_gy_ff    <= grad_ff[1];
            o_gz_ff    <= grad_ff[2];
            o_len_ff   <= (|len_ff[LEN_W-1:WORD_W]) ? {WORD_W{1'b1}} : len_ff[WORD_W-1:0];
            o_en_ff    <= energy_sum_ff;
            o_last_ff  <= last_ff;
            o_degen_ff <= (len_ff == '0);
         end
         default: ;
      endcase
   end

   assign sts.out_stall = rsp_valid_ff && !rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign out_index_a   = o_idx_a_ff;
   assign out_index_b   = o_idx_b_ff;
   assign grad_x        = o_gx_ff;
   assign grad_y        = o_gy_ff;
   assign grad_z        = o_gz_ff;
   assign edge_length   = o_len_ff;
   assign energy        = o_en_ff;
   assign last          = o_last_ff;
   assign degenerate    = o_degen_ff;

endmodule
`default_nettype wire

@@ rtl/hes_ctrl.sv @@
// Controller: sequences the datapath through load, squares, root, energy and gradients.
`default_nettype none
module hes_ctrl import hes_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire sts_type sts,
   output      cmd_type cmd
);

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_SQ_INIT   = 5'd1;
   localparam logic [4:0] S_SQ_MUL    = 5'd2;
   localparam logic [4:0] S_SQ_ACC    = 5'd3;
   localparam logic [4:0] S_SQRT_INIT = 5'd4;
   localparam logic [4:0] S_SQRT      = 5'd5;
   localparam logic [4:0] S_DEV       = 5'd6;
   localparam logic [4:0] S_E1_INIT   = 5'd7;
   localparam logic [4:0] S_E1_MUL    = 5'd8;
   localparam logic [4:0] S_E2_INIT   = 5'd9;
   localparam logic [4:0] S_E2_MUL    = 5'd10;
   localparam logic [4:0] S_EDIV_INIT = 5'd11;
   localparam logic [4:0] S_EDIV      = 5'd12;
   localparam logic [4:0] S_ENERGY    = 5'd13;
   localparam logic [4:0] S_DEN_INIT  = 5'd14;
   localparam logic [4:0] S_DEN_MUL   = 5'd15;
   localparam logic [4:0] S_DEN_SAVE  = 5'd16;
   localparam logic [4:0] S_G1_INIT   = 5'd17;
   localparam logic [4:0] S_G1_MUL    = 5'd18;
   localparam logic [4:0] S_G2_INIT   = 5'd19;
   localparam logic [4:0] S_G2_MUL    = 5'd20;
   localparam logic [4:0] S_GDIV_INIT = 5'd21;
   localparam logic [4:0] S_GDIV      = 5'd22;
   localparam logic [4:0] S_GRAD      = 5'd23;
   localparam logic [4:0] S_FINISH    = 5'd24;

   localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS - 1);
   localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(SQRT_STEPS - 1);
   localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(DIV_STEPS - 1);
   localparam logic [1:0]       AXIS_LAST = 2'd2;

   logic [4:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       axis_ff, axis_in;
   logic             cnt_zero;

   assign cnt_zero  = (cnt_ff == '0);
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_zero ? cnt_ff : cnt_ff - CNT_W'(1);
      axis_in  = axis_ff;
      cmd.op   = OP_NOP;
      cmd.sel  = axis_ff;
      unique case (state_ff)
         S_IDLE: begin
            axis_in = '0;
            if (req_valid) begin
               cmd.op   = OP_LOAD;
               state_in = S_SQ_INIT;
            end
         end
         S_SQ_INIT: begin
            cmd.op = OP_SQ_INIT; cnt_in = MUL_LAST; state_in = S_SQ_MUL;
         end
         S_SQ_MUL: begin
            cmd.op = OP_MUL_STEP;
            if (cnt_zero) state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            cmd.op = OP_SQ_ACC;
            if (axis_ff == AXIS_LAST) begin
               axis_in = '0; state_in = S_SQRT_INIT;
            end else begin
               axis_in = axis_ff + 2'd1; state_in = S_SQ_INIT;
            end
         end
         S_SQRT_INIT: begin
            cmd.op = OP_SQRT_INIT; cnt_in = SQRT_LAST; state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = OP_SQRT_STEP;
            if (cnt_zero) state_in = S_DEV;
         end
         S_DEV: begin
            cmd.op = OP_DEV; state_in = S_E1_INIT;
         end
         S_E1_INIT: begin
            cmd.op = OP_E1_INIT; cnt_in = MUL_LAST; state_in = S_E1_MUL;
         end
         S_E1_MUL: begin
            cmd.op = OP_MUL_STEP;
            if (cnt_zero) state_in = S_E2_INIT;
         end
         S_E2_INIT: begin
            cmd.op = OP_E2_INIT; cnt_in = MUL_LAST; state_in = S_E2_MUL;
         end
         S_E2_MUL: begin
            cmd.op = OP_MUL_STEP;
            if (cnt_zero) state_in = S_EDIV_INIT;
         end
         S_EDIV_INIT: begin
            cmd.op = OP_EDIV_INIT; cnt_in = DIV_LAST; state_in = S_EDIV;
         end
         S_EDIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_zero) state_in = S_ENERGY;
         end
         S_ENERGY: begin
            cmd.op = OP_ENERGY; state_in = S_DEN_INIT;
         end
         S_DEN_INIT: begin
            cmd.op = OP_DEN_INIT; cnt_in = MUL_LAST; state_in = S_DEN_MUL;
         end
         S_DEN_MUL: begin
            cmd.op = OP_MUL_STEP;
            if (cnt_zero) state_in = S_DEN_SAVE;
         end
         S_DEN_SAVE: begin
            cmd.op = OP_DEN_SAVE; state_in = S_G1_INIT;
         end
         S_G1_INIT: begin
            cmd.op = OP_G1_INIT; cnt_in = MUL_LAST; state_in = S_G1_MUL;
         end
         S_G1_MUL: begin
            cmd.op = OP_MUL_STEP;
            if (cnt_zero) state_in = S_G2_INIT;
         end
         S_G2_INIT: begin
            cmd.op = OP_G2_INIT; cnt_in = MUL_LAST; state_in = S_G2_MUL;
         end
         S_G2_MUL: begin
            cmd.op = OP_MUL_STEP;
            if (cnt_zero) state_in = S_GDIV_INIT;
         end
         S_GDIV_INIT: begin
            cmd.op = OP_GDIV_INIT; cnt_in = DIV_LAST; state_in = S_GDIV;
         end
         S_GDIV: begin
            cmd.op = OP_DIV_STEP;
            if (cnt_zero) state_in = S_GRAD;
         end
         S_GRAD: begin
            cmd.op = OP_GRAD;
            if (axis_ff == AXIS_LAST) begin
               state_in = S_FINISH;
            end else begin
               axis_in = axis_ff + 2'd1; state_in = S_G1_INIT;
            end
         end
         S_FINISH: begin
            if (!sts.out_stall) begin
               cmd.op = OP_FINISH; state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         axis_ff  <= axis_in;
      end
   end

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("controller took a second transaction while busy");
   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_FINISH |-> !sts.out_stall)
      else $error("result overwritten while still held");
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      axis_ff != 2'd3)
      else $error("axis select out of range");
   a_load_only_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.op == OP_LOAD |-> $past(state_in) == S_IDLE || state_ff == S_IDLE)
      else $error("load issued outside idle");
`endif

endmodule
`default_nettype wire

@@ rtl/harmonic_edge_spring.sv @@
// Top level of the harmonic edge spring: edge length, energy accumulate and gradient.
// Edges are processed one at a time, paced by the shared shift-add multiplier
//   (12 products per edge) and the restoring divider (4 quotients per edge).
// A new request is taken while the previous result still waits in the output register.
// Reset (synchronous, active high): idle, result channel empty, energy sum zero,
//   rest_length and stiffness back to 1.0.
`default_nettype none
module harmonic_edge_spring import hes_pkg::*; #(
   parameter int VERTEX_INDEX_BITS = VERTEX_INDEX_BITS_DEF,
   parameter int FRAC_BITS         = FRAC_BITS_DEF
) (
   input wire logic clock,
   input wire logic reset,
   hes_req_if.sink   req_chan,
   hes_rsp_if.source rsp_chan,
   hes_csr_if.sink   csr_chan
);

   cmd_type cmd;   // controller -> datapath micro-op
   sts_type sts;   // datapath -> controller status

   // register writes are always accepted; software is to write only when idle, unenforced by the block
   assign csr_chan.ready = 1'b1;

   // sequencer: one micro-op per cycle, held in the finish state while the result register is stalled
   hes_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // arithmetic, config registers, energy accumulator and result register
   hes_datapath #(
      .VERTEX_INDEX_BITS (VERTEX_INDEX_BITS),
      .FRAC_BITS         (FRAC_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .csr_valid   (csr_chan.valid),
      .csr_index   (csr_chan.index),
      .csr_data    (csr_chan.data),
      .index_a     (req_chan.index_a),
      .index_b     (req_chan.index_b),
      .pos_ax      (req_chan.pos_ax),
      .pos_ay      (req_chan.pos_ay),
      .pos_az      (req_chan.pos_az),
      .pos_bx      (req_chan.pos_bx),
      .pos_by      (req_chan.pos_by),
      .pos_bz      (req_chan.pos_bz),
      .last_edge   (req_chan.last_edge),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .out_index_a (rsp_chan.out_index_a),
      .out_index_b (rsp_chan.out_index_b),
      .grad_x      (rsp_chan.grad_x),
      .grad_y      (rsp_chan.grad_y),
      .grad_z      (rsp_chan.grad_z),
      .edge_length (rsp_chan.edge_length),
      .energy      (rsp_chan.energy),
      .last        (rsp_chan.last),
      .degenerate  (rsp_chan.degenerate)
   );

endmodule
`default_nettype wire
